// ===== rtl/core/pdq_pkg.sv =====
// Shared types, constants and the step microprogram of the PMSM dq RK4 emulator.
// Used by pdq_alu and pmsm_dq_rk4_step; depends on nothing else.
package pdq_pkg;

	localparam int WORD   = 48;
	localparam int FRAC   = 24;
	localparam int HALF_W = WORD / 2;
	localparam int DIVW   = WORD + FRAC;
	localparam int CFGW   = 47;

	typedef logic signed [WORD-1:0] word_t;

	localparam word_t WMAX = word_t'({1'b0, {(WORD-1){1'b1}}});
	localparam word_t WMIN = word_t'({1'b1, {(WORD-1){1'b0}}});

	// Fixed-point constants in Q24.24.
	localparam word_t C_TH15  = word_t'(64'd3 << (FRAC - 1));
	localparam word_t C_SIX   = word_t'(64'd6 << FRAC);
	localparam word_t C_HALF  = word_t'(64'd1 << (FRAC - 1));
	localparam word_t C_TWOPI = word_t'(64'd105414357);

	// Configuration register indexes.
	localparam logic [3:0] CFG_POLE_PAIRS = 4'd0;
	localparam logic [3:0] CFG_RS         = 4'd1;
	localparam logic [3:0] CFG_LD         = 4'd2;
	localparam logic [3:0] CFG_LQ         = 4'd3;
	localparam logic [3:0] CFG_PHI        = 4'd4;
	localparam logic [3:0] CFG_JINV       = 4'd5;
	localparam logic [3:0] CFG_FB         = 4'd6;
	localparam logic [3:0] CFG_TS         = 4'd7;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_WHI, OP_WLO, OP_LOOP, OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] dst;
		logic [5:0] a;
		logic [5:0] b;
	} instr_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		word_t result;
	} alu_rsp_t;

	// Operand codes. Codes below 32 address the scratch memory.
	localparam logic [5:0] T_HH   = 6'd0;
	localparam logic [5:0] T_SH   = 6'd1;
	localparam logic [5:0] T_LMQ  = 6'd2;
	localparam logic [5:0] T_PK   = 6'd3;
	localparam logic [5:0] T_XD   = 6'd4;
	localparam logic [5:0] T_XQ   = 6'd5;
	localparam logic [5:0] T_XW   = 6'd6;
	localparam logic [5:0] K_BASE = 6'd8;
	localparam logic [5:0] T_A    = 6'd24;
	localparam logic [5:0] T_B    = 6'd25;
	localparam logic [5:0] R_ID    = 6'd32;
	localparam logic [5:0] R_IQ    = 6'd33;
	localparam logic [5:0] R_WM    = 6'd34;
	localparam logic [5:0] R_TH    = 6'd35;
	localparam logic [5:0] R_VD    = 6'd36;
	localparam logic [5:0] R_VQ    = 6'd37;
	localparam logic [5:0] R_TL    = 6'd38;
	localparam logic [5:0] R_RS    = 6'd39;
	localparam logic [5:0] R_LD    = 6'd40;
	localparam logic [5:0] R_LQ    = 6'd41;
	localparam logic [5:0] R_PHI   = 6'd42;
	localparam logic [5:0] R_JINV  = 6'd43;
	localparam logic [5:0] R_FB    = 6'd44;
	localparam logic [5:0] R_TS    = 6'd45;
	localparam logic [5:0] R_PP    = 6'd46;
	localparam logic [5:0] R_TH15  = 6'd47;
	localparam logic [5:0] R_TWOPI = 6'd48;
	localparam logic [5:0] R_SIX   = 6'd49;
	localparam logic [5:0] R_HALF  = 6'd50;
	localparam logic [5:0] R_TE    = 6'd51;
	// Codes that depend on the derivative pass.
	localparam logic [5:0] I_XD = 6'd52;
	localparam logic [5:0] I_XQ = 6'd53;
	localparam logic [5:0] I_XW = 6'd54;
	localparam logic [5:0] I_KD = 6'd55;
	localparam logic [5:0] I_KQ = 6'd56;
	localparam logic [5:0] I_KW = 6'd57;
	localparam logic [5:0] I_KT = 6'd58;
	localparam logic [5:0] I_H  = 6'd59;

	localparam logic [6:0] LOOP_PC = 7'd4;

	function automatic instr_t ins(op_t op, logic [5:0] d, logic [5:0] a, logic [5:0] b);
		instr_t i;
		i.op  = op;
		i.dst = d;
		i.a   = a;
		i.b   = b;
		return i;
	endfunction

	// Slot of derivative component c of pass p.
	function automatic logic [5:0] kslot(logic [1:0] p, logic [1:0] c);
		return K_BASE + {2'b00, p, 2'b00} + {4'b0000, c};
	endfunction

	function automatic logic [5:0] resolve(logic [5:0] code, logic [1:0] pass);
		logic [5:0] r;
		unique case (code)
			I_XD:    r = (pass == 2'd0) ? R_ID : T_XD;
			I_XQ:    r = (pass == 2'd0) ? R_IQ : T_XQ;
			I_XW:    r = (pass == 2'd0) ? R_WM : T_XW;
			I_KD:    r = kslot(pass, 2'd0);
			I_KQ:    r = kslot(pass, 2'd1);
			I_KW:    r = kslot(pass, 2'd2);
			I_KT:    r = kslot(pass, 2'd3);
			I_H:     r = (pass == 2'd2) ? R_TS : T_HH;
			default: r = code;
		endcase
		return r;
	endfunction

	// The microprogram: precompute, four derivative passes with the
	// intermediate states, the weighted sum, the angle wrap and the torque.
	function automatic instr_t prog(logic [6:0] pc);
		instr_t i;
		case (pc)
			7'd0:  i = ins(OP_MUL, T_HH, R_HALF, R_TS);
			7'd1:  i = ins(OP_DIV, T_SH, R_TS, R_SIX);
			7'd2:  i = ins(OP_SUB, T_LMQ, R_LD, R_LQ);
			7'd3:  i = ins(OP_MUL, T_PK, R_TH15, R_PP);
			7'd4:  i = ins(OP_MUL, I_KT, R_PP, I_XW);
			7'd5:  i = ins(OP_MUL, T_A, R_RS, I_XD);
			7'd6:  i = ins(OP_SUB, T_A, R_VD, T_A);
			7'd7:  i = ins(OP_MUL, T_B, I_KT, R_LQ);
			7'd8:  i = ins(OP_MUL, T_B, T_B, I_XQ);
			7'd9:  i = ins(OP_ADD, T_A, T_A, T_B);
			7'd10: i = ins(OP_DIV, I_KD, T_A, R_LD);
			7'd11: i = ins(OP_MUL, T_A, R_RS, I_XQ);
			7'd12: i = ins(OP_SUB, T_A, R_VQ, T_A);
			7'd13: i = ins(OP_MUL, T_B, R_LD, I_XD);
			7'd14: i = ins(OP_ADD, T_B, T_B, R_PHI);
			7'd15: i = ins(OP_MUL, T_B, I_KT, T_B);
			7'd16: i = ins(OP_SUB, T_A, T_A, T_B);
			7'd17: i = ins(OP_DIV, I_KQ, T_A, R_LQ);
			7'd18: i = ins(OP_MUL, T_A, R_PHI, I_XQ);
			7'd19: i = ins(OP_MUL, T_B, T_LMQ, I_XD);
			7'd20: i = ins(OP_MUL, T_B, T_B, I_XQ);
			7'd21: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd22: i = ins(OP_MUL, T_A, T_PK, T_A);
			7'd23: i = ins(OP_SUB, T_A, T_A, R_TL);
			7'd24: i = ins(OP_MUL, T_B, R_FB, I_XW);
			7'd25: i = ins(OP_SUB, T_A, T_A, T_B);
			7'd26: i = ins(OP_MUL, I_KW, T_A, R_JINV);
			7'd27: i = ins(OP_MUL, T_XD, I_H, I_KD);
			7'd28: i = ins(OP_ADD, T_XD, R_ID, T_XD);
			7'd29: i = ins(OP_MUL, T_XQ, I_H, I_KQ);
			7'd30: i = ins(OP_ADD, T_XQ, R_IQ, T_XQ);
			7'd31: i = ins(OP_MUL, T_XW, I_H, I_KW);
			7'd32: i = ins(OP_ADD, T_XW, R_WM, T_XW);
			7'd33: i = ins(OP_LOOP, T_A, T_A, T_A);
			7'd34: i = ins(OP_ADD, T_A, kslot(2'd1, 2'd0), kslot(2'd1, 2'd0));
			7'd35: i = ins(OP_ADD, T_A, kslot(2'd0, 2'd0), T_A);
			7'd36: i = ins(OP_ADD, T_B, kslot(2'd2, 2'd0), kslot(2'd2, 2'd0));
			7'd37: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd38: i = ins(OP_ADD, T_A, T_A, kslot(2'd3, 2'd0));
			7'd39: i = ins(OP_MUL, T_A, T_SH, T_A);
			7'd40: i = ins(OP_ADD, R_ID, R_ID, T_A);
			7'd41: i = ins(OP_ADD, T_A, kslot(2'd1, 2'd1), kslot(2'd1, 2'd1));
			7'd42: i = ins(OP_ADD, T_A, kslot(2'd0, 2'd1), T_A);
			7'd43: i = ins(OP_ADD, T_B, kslot(2'd2, 2'd1), kslot(2'd2, 2'd1));
			7'd44: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd45: i = ins(OP_ADD, T_A, T_A, kslot(2'd3, 2'd1));
			7'd46: i = ins(OP_MUL, T_A, T_SH, T_A);
			7'd47: i = ins(OP_ADD, R_IQ, R_IQ, T_A);
			7'd48: i = ins(OP_ADD, T_A, kslot(2'd1, 2'd2), kslot(2'd1, 2'd2));
			7'd49: i = ins(OP_ADD, T_A, kslot(2'd0, 2'd2), T_A);
			7'd50: i = ins(OP_ADD, T_B, kslot(2'd2, 2'd2), kslot(2'd2, 2'd2));
			7'd51: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd52: i = ins(OP_ADD, T_A, T_A, kslot(2'd3, 2'd2));
			7'd53: i = ins(OP_MUL, T_A, T_SH, T_A);
			7'd54: i = ins(OP_ADD, R_WM, R_WM, T_A);
			7'd55: i = ins(OP_ADD, T_A, kslot(2'd1, 2'd3), kslot(2'd1, 2'd3));
			7'd56: i = ins(OP_ADD, T_A, kslot(2'd0, 2'd3), T_A);
			7'd57: i = ins(OP_ADD, T_B, kslot(2'd2, 2'd3), kslot(2'd2, 2'd3));
			7'd58: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd59: i = ins(OP_ADD, T_A, T_A, kslot(2'd3, 2'd3));
			7'd60: i = ins(OP_MUL, T_A, T_SH, T_A);
			7'd61: i = ins(OP_ADD, R_TH, R_TH, T_A);
			7'd62: i = ins(OP_WHI, R_TH, R_TH, R_TWOPI);
			7'd63: i = ins(OP_WLO, R_TH, R_TH, R_TWOPI);
			7'd64: i = ins(OP_MUL, T_A, R_PHI, R_IQ);
			7'd65: i = ins(OP_MUL, T_B, T_LMQ, R_ID);
			7'd66: i = ins(OP_MUL, T_B, T_B, R_IQ);
			7'd67: i = ins(OP_ADD, T_A, T_A, T_B);
			7'd68: i = ins(OP_MUL, R_TE, T_PK, T_A);
			default: i = ins(OP_END, T_A, T_A, T_A);
		endcase
		return i;
	endfunction

endpackage

// ===== rtl/core/pdq_alu.sv =====
// Shared saturating arithmetic unit: add, subtract, angle wrap steps,
// a 48x48 multiplier summing four 24x24 partial products and a bit-serial divider.
// Depends on pdq_pkg.
module pdq_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  pdq_pkg::alu_req_t req,
	input  pdq_pkg::word_t    a,
	input  pdq_pkg::word_t    b,
	output pdq_pkg::alu_rsp_t rsp
);
	import pdq_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} alu_state_t;

	alu_state_t           st_q;
	logic                 done_q;
	word_t                res_q;
	logic                 neg_q;
	logic                 is_div_q;
	logic [WORD-1:0]      xm_q, ym_q, dm_q, rem_q;
	logic [2*WORD-1:0]    acc_q;
	logic [DIVW-1:0]      div_q;
	logic [6:0]           cnt_q;

	word_t                addend, add_sat, add_res;
	logic [WORD:0]        sum;
	logic [WORD-1:0]      am, bm;
	logic [HALF_W-1:0]    xp, yp;
	logic [WORD-1:0]      pp;
	logic [2*WORD-1:0]    psh;
	logic [WORD:0]        remsh;
	logic                 ge;

	function automatic word_t sneg(word_t v);
		return (v == WMIN || v == WMIN + word_t'(1)) ? WMAX : -v;
	endfunction

	function automatic word_t sat_mag(logic neg, logic [DIVW-1:0] m);
		logic [DIVW-1:0] lim;
		logic [WORD-1:0] low;
		lim = DIVW'(WMAX) + DIVW'(neg);
		low = m[WORD-1:0];
		if (m > lim) begin
			return neg ? WMIN : WMAX;
		end
		return neg ? word_t'(-low) : word_t'(low);
	endfunction

	always_comb begin
		addend = (req.op == OP_SUB || req.op == OP_WHI) ? sneg(b) : b;
		sum = {a[WORD-1], a} + {addend[WORD-1], addend};
		if (sum[WORD] != sum[WORD-1]) begin
			add_sat = sum[WORD] ? WMIN : WMAX;
		end else begin
			add_sat = word_t'(sum[WORD-1:0]);
		end
		case (req.op)
			OP_WHI:  add_res = (a > b) ? add_sat : a;
			OP_WLO:  add_res = sum[WORD] ? add_sat : a;
			default: add_res = add_sat;
		endcase
		am = a[WORD-1] ? WORD'(-a) : WORD'(a);
		bm = b[WORD-1] ? WORD'(-b) : WORD'(b);

		xp = cnt_q[1] ? xm_q[WORD-1:HALF_W] : xm_q[HALF_W-1:0];
		yp = cnt_q[0] ? ym_q[WORD-1:HALF_W] : ym_q[HALF_W-1:0];
		pp = xp * yp;
		case (cnt_q[1:0])
			2'd0:    psh = {{WORD{1'b0}}, pp};
			2'd3:    psh = {pp, {WORD{1'b0}}};
			default: psh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
		endcase

		remsh = {rem_q, div_q[DIVW-1]};
		ge = remsh >= {1'b0, dm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (req.start) begin
						case (req.op)
							OP_MUL: begin
								xm_q   <= am;
								ym_q   <= bm;
								neg_q  <= a[WORD-1] ^ b[WORD-1];
								acc_q  <= '0;
								cnt_q  <= '0;
								done_q <= 1'b0;
								st_q   <= ST_MUL;
							end
							OP_DIV: begin
								if (am == '0) begin
									res_q  <= '0;
									done_q <= 1'b1;
								end else if (bm == '0) begin
									res_q  <= a[WORD-1] ? WMIN : WMAX;
									done_q <= 1'b1;
								end else begin
									div_q  <= {am, {FRAC{1'b0}}};
									rem_q  <= '0;
									dm_q   <= bm;
									neg_q  <= a[WORD-1] ^ b[WORD-1];
									cnt_q  <= '0;
									done_q <= 1'b0;
									st_q   <= ST_DIV;
								end
							end
							default: begin
								res_q  <= add_res;
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_MUL: begin
					acc_q <= acc_q + psh;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd3) begin
						is_div_q <= 1'b0;
						st_q     <= ST_FIN;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? WORD'(remsh - {1'b0, dm_q}) : remsh[WORD-1:0];
					div_q <= {div_q[DIVW-2:0], ge};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(DIVW - 1)) begin
						is_div_q <= 1'b1;
						st_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q  <= sat_mag(neg_q, is_div_q ? div_q : acc_q[2*WORD-1:FRAC]);
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ===== rtl/core/pmsm_dq_rk4_step.sv =====
// PMSM dq motor emulator: one fourth-order Runge-Kutta step per input word,
// run by a microprogram sequencer over a 32-entry scratch memory and pdq_alu.
// Depends on pdq_pkg and pdq_alu.
//
// Each accepted input word (d/q voltages and load torque, Q24.24) advances the
// held motor state (d/q currents, mechanical speed, electrical angle) by one
// RK4 step of step_time and produces one result word with the new state and
// the electromagnetic torque. Every operation goes through the single shared
// arithmetic unit, where a divide yields one quotient bit per cycle, and a step
// holds 9 divides and 74 multiplies. The input is not ready during a step; a
// finished result waits in the output register, and the next word is accepted
// while it waits. The user must see that configuration is written only while
// the block is idle; the block itself does not enforce this.
module pmsm_dq_rk4_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_index,
	input  logic [pdq_pkg::CFGW-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pdq_pkg::word_t        voltage_d,
	input  pdq_pkg::word_t        voltage_q,
	input  pdq_pkg::word_t        load_torque,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pdq_pkg::word_t        current_d_out,
	output pdq_pkg::word_t        current_q_out,
	output pdq_pkg::word_t        speed_out,
	output pdq_pkg::word_t        angle_out,
	output pdq_pkg::word_t        torque_out
);
	import pdq_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_FETCH, S_ISSUE, S_WAIT, S_DONE} seq_state_t;

	seq_state_t        state_q;
	logic [6:0]        pc_q;
	logic [1:0]        pass_q;
	op_t               op_q;
	logic [5:0]        dst_q, srca_q, srcb_q;

	logic [4:0]        pp_q;
	logic [CFGW-1:0]   rs_q, ld_q, lq_q, phi_q, jinv_q, fb_q, ts_q;
	word_t             vd_q, vq_q, tl_q;
	word_t             id_q, iq_q, wm_q, th_q, te_q;
	logic              out_valid_q;
	word_t             od_q, oq_q, ow_q, oth_q, ote_q;

	word_t             mem [32];
	word_t             rda_q, rdb_q;

	instr_t            cur;
	logic [5:0]        res_a, res_b, res_d;
	word_t             opa, opb;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic              wr_mem;

	function automatic word_t fixed_val(
		logic [5:0] code, word_t id, word_t iq, word_t wm, word_t th, word_t te,
		word_t vd, word_t vq, word_t tl, logic [4:0] pp,
		logic [CFGW-1:0] rs, logic [CFGW-1:0] ld, logic [CFGW-1:0] lq,
		logic [CFGW-1:0] phi, logic [CFGW-1:0] jinv, logic [CFGW-1:0] fb,
		logic [CFGW-1:0] ts);
		word_t v;
		unique case (code)
			R_ID:    v = id;
			R_IQ:    v = iq;
			R_WM:    v = wm;
			R_TH:    v = th;
			R_TE:    v = te;
			R_VD:    v = vd;
			R_VQ:    v = vq;
			R_TL:    v = tl;
			R_RS:    v = word_t'(rs);
			R_LD:    v = word_t'(ld);
			R_LQ:    v = word_t'(lq);
			R_PHI:   v = word_t'(phi);
			R_JINV:  v = word_t'(jinv);
			R_FB:    v = word_t'(fb);
			R_TS:    v = word_t'(ts);
			R_PP:    v = word_t'(WORD'(pp) << FRAC);
			R_TH15:  v = C_TH15;
			R_TWOPI: v = C_TWOPI;
			R_SIX:   v = C_SIX;
			R_HALF:  v = C_HALF;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		cur   = prog(pc_q);
		res_a = resolve(cur.a, pass_q);
		res_b = resolve(cur.b, pass_q);
		res_d = resolve(cur.dst, pass_q);
		opa = srca_q[5] ? fixed_val(srca_q, id_q, iq_q, wm_q, th_q, te_q, vd_q, vq_q, tl_q,
			pp_q, rs_q, ld_q, lq_q, phi_q, jinv_q, fb_q, ts_q) : rda_q;
		opb = srcb_q[5] ? fixed_val(srcb_q, id_q, iq_q, wm_q, th_q, te_q, vd_q, vq_q, tl_q,
			pp_q, rs_q, ld_q, lq_q, phi_q, jinv_q, fb_q, ts_q) : rdb_q;
		alu_req.start = (state_q == S_ISSUE);
		alu_req.op    = op_q;
		wr_mem = (state_q == S_WAIT) && alu_rsp.done && !dst_q[5];
	end

	pdq_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opa),
		.b      (opb),
		.rsp    (alu_rsp)
	);

	// Scratch memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_mem) begin
			mem[dst_q[4:0]] <= alu_rsp.result;
		end
		if (state_q == S_FETCH) begin
			rda_q <= mem[res_a[4:0]];
			rdb_q <= mem[res_b[4:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q   <= 5'd1;
			rs_q   <= CFGW'(64'd1090519040);
			ld_q   <= CFGW'(64'd2181038);
			lq_q   <= CFGW'(64'd2181038);
			phi_q  <= CFGW'(64'd1342177);
			jinv_q <= CFGW'(64'd76260071965);
			fb_q   <= CFGW'(64'd1678);
			ts_q   <= CFGW'(64'd2097);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLE_PAIRS: pp_q   <= cfg_data[4:0];
				CFG_RS:         rs_q   <= cfg_data;
				CFG_LD:         ld_q   <= cfg_data;
				CFG_LQ:         lq_q   <= cfg_data;
				CFG_PHI:        phi_q  <= cfg_data;
				CFG_JINV:       jinv_q <= cfg_data;
				CFG_FB:         fb_q   <= cfg_data;
				CFG_TS:         ts_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
			id_q        <= '0;
			iq_q        <= '0;
			wm_q        <= '0;
			th_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						vd_q    <= voltage_d;
						vq_q    <= voltage_q;
						tl_q    <= load_torque;
						pc_q    <= '0;
						pass_q  <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (cur.op == OP_LOOP) begin
						if (pass_q != 2'd3) begin
							pass_q <= pass_q + 2'd1;
							pc_q   <= LOOP_PC;
						end else begin
							pc_q <= pc_q + 7'd1;
						end
					end else if (cur.op == OP_END) begin
						state_q <= S_DONE;
					end else begin
						op_q    <= cur.op;
						dst_q   <= res_d;
						srca_q  <= res_a;
						srcb_q  <= res_b;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_rsp.done) begin
						case (dst_q)
							R_ID:    id_q <= alu_rsp.result;
							R_IQ:    iq_q <= alu_rsp.result;
							R_WM:    wm_q <= alu_rsp.result;
							R_TH:    th_q <= alu_rsp.result;
							R_TE:    te_q <= alu_rsp.result;
							default: ;
						endcase
						pc_q    <= pc_q + 7'd1;
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					// Hold the finished step until the output register frees up.
					if (!out_valid_q || out_ready) begin
						od_q        <= id_q;
						oq_q        <= iq_q;
						ow_q        <= wm_q;
						oth_q       <= th_q;
						ote_q       <= te_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign current_d_out = od_q;
	assign current_q_out = oq_q;
	assign speed_out     = ow_q;
	assign angle_out     = oth_q;
	assign torque_out    = ote_q;

endmodule
